/* design/keypad_scan_debounce_i2c_expander_unit_assert.svh */
// Assertion macros shared by the keypad scanner RTL.
`ifndef KEYPAD_SCAN_DEBOUNCE_I2C_EXPANDER_UNIT_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_I2C_EXPANDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define KPD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Check that a condition in one cycle implies another in the next.
`define KPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define KPD_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define KPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/kpdscan_pkg.sv */
`timescale 1ns / 1ps

package kpdscan_pkg;

   localparam int DEFAULT_ROWS = 6;
   localparam int DEFAULT_COLS = 8;

   localparam int OP_W      = 3;
   localparam int BYTE_W    = 8;
   localparam int ROW_IDX_W = 3;
   localparam int REQ_W     = 2 * BYTE_W;
   localparam int RSP_FIELDS_W = 5 * BYTE_W + ROW_IDX_W;
   localparam int RSP_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd40;
   localparam logic [BYTE_W-1:0] READ_PAD    = 8'hFF;

   localparam logic [OP_W-1:0] OP_SCAN  = 3'd0;
   localparam logic [OP_W-1:0] OP_WADDR = 3'd1;
   localparam logic [OP_W-1:0] OP_WBYTE = 3'd2;
   localparam logic [OP_W-1:0] OP_RADDR = 3'd3;
   localparam logic [OP_W-1:0] OP_RBYTE = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0]    row_state;
      logic [ROW_IDX_W-1:0] row_index;
      logic [BYTE_W-1:0]    row_drive;
      logic [BYTE_W-1:0]    read_byte;
      logic [BYTE_W-1:0]    port_d;
      logic [BYTE_W-1:0]    port_b;
   } rsp_type;

endpackage

/* design/kpdscan_skid.sv */
`timescale 1ns / 1ps

`include "keypad_scan_debounce_i2c_expander_unit_assert.svh"

module kpdscan_skid import kpdscan_pkg::*; #(
   parameter int WIDTH = RSP_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] slot0_ff, slot0_in;
   logic [WIDTH-1:0] slot1_ff, slot1_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot0_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = in_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = in_data;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = in_data;
         end else begin
            slot1_in = in_data;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   `KPD_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff != 2'd3)
   `KPD_ASSERT_NEXT(a_full_holds, clock, reset, count_ff == 2'd2 && !out_ready,
                    count_ff == 2'd2)
   `KPD_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push,
                    count_ff == $past(count_ff) - 2'd1)

endmodule

/* design/keypad_scan_debounce_i2c_expander_unit.sv */
`timescale 1ns / 1ps
// Keypad matrix scanner and debouncer with a byte-wide register front.
// Input channel req_*: one beat per event. req_tuser carries the operation
// (scan tick, write address, write byte, read address, read byte); req_tdata
// carries the sampled column bits and the bus data byte.
// Result channel rsp_*: exactly one beat per accepted input beat, in order,
// carrying both output ports, the read byte, the row drive pattern, the
// scanned row and the debounced row byte.
// Each beat is processed in the cycle it is accepted; its result is
// registered. One beat per cycle is sustained while rsp_tready is high, set
// by the single pass through the key counter update and the two-entry
// output buffer. csr_we/csr_wdata load the debounce limit; write it only
// while idle. Reset (synchronous) clears all key counters, debounced rows,
// row and bus pointers and both ports, and loads the limit with 40.
// When rsp_tready is low the output buffer holds up to two results;
// req_tready drops once both entries are occupied and rises as soon as one
// is taken.

`include "keypad_scan_debounce_i2c_expander_unit_assert.svh"

module keypad_scan_debounce_i2c_expander_unit import kpdscan_pkg::*; #(
   parameter int ROWS = DEFAULT_ROWS,
   parameter int COLS = DEFAULT_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [7:0] column_bits, [15:8] data_byte
   input  logic [REQ_W-1:0]  req_tdata,
   // [2:0] operation
   input  logic [OP_W-1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [7:0] port_b, [15:8] port_d, [23:16] read_byte, [31:24] row_drive,
   // [34:32] row_index, [42:35] row_state, [47:43] zero
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata
);

   localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RD_W   = $clog2(ROWS + 1);

   logic [BYTE_W-1:0] limit_ff;
   logic [RIDX_W-1:0] scan_row_ff, scan_row_in;
   logic [COLS-1:0][BYTE_W-1:0] cnt_ff [ROWS];
   logic [BYTE_W-1:0] cnt_row_in [COLS];
   logic [BYTE_W-1:0] deb_ff [ROWS];
   logic              write_index_ff, write_index_in;
   logic [RD_W-1:0]   read_index_ff, read_index_in;
   logic [BYTE_W-1:0] port_b_ff, port_b_in;
   logic [BYTE_W-1:0] port_d_ff, port_d_in;

   logic [RIDX_W-1:0] row_next;
   logic [BYTE_W-1:0] row_bits;
   logic              req_accept;
   logic              scan_we;
   logic [COLS-1:0]   col_in;
   logic [BYTE_W-1:0] data_in;
   rsp_type           rsp;
   logic [RSP_W-1:0]  rsp_vec;
   logic              buf_ready;

   assign req_tready = buf_ready;
   assign req_accept = req_tvalid && buf_ready;
   assign col_in     = req_tdata[COLS-1:0];
   assign data_in    = req_tdata[2*BYTE_W-1:BYTE_W];
   assign row_next   = (scan_row_ff == RIDX_W'(ROWS - 1)) ? '0 : scan_row_ff + 1'b1;

   // per-column debounce of the next row
   always_comb begin
      row_bits = '0;
      for (int c = 0; c < COLS; c++) begin
         cnt_row_in[c] = cnt_ff[row_next][c];
         if (col_in[c]) begin
            if (cnt_ff[row_next][c] < limit_ff) begin
               cnt_row_in[c] = cnt_ff[row_next][c] + 1'b1;
            end else begin
               row_bits[c] = 1'b1;
            end
         end else begin
            cnt_row_in[c] = '0;
         end
      end
   end

   always_comb begin
      scan_row_in    = scan_row_ff;
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      port_b_in      = port_b_ff;
      port_d_in      = port_d_ff;
      scan_we        = 1'b0;
      rsp.read_byte  = '0;
      rsp.row_state  = '0;
      unique case (req_tuser)
         OP_SCAN: begin
            scan_we       = req_accept;
            scan_row_in   = row_next;
            rsp.row_state = row_bits;
         end
         OP_WADDR: begin
            write_index_in = 1'b0;
         end
         OP_WBYTE: begin
            write_index_in = !write_index_ff;
            if (!write_index_ff) begin
               port_b_in = data_in;
            end else begin
               port_d_in = data_in;
            end
         end
         OP_RADDR: begin
            read_index_in = RD_W'(1);
            rsp.read_byte = deb_ff[0];
         end
         OP_RBYTE: begin
            if (read_index_ff >= RD_W'(ROWS)) begin
               rsp.read_byte = READ_PAD;
            end else begin
               rsp.read_byte = deb_ff[read_index_ff[RIDX_W-1:0]];
               read_index_in = read_index_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp.port_b    = port_b_in;
      rsp.port_d    = port_d_in;
      rsp.row_index = ROW_IDX_W'(scan_row_in);
      rsp.row_drive = BYTE_W'(1) << (ROW_IDX_W'(scan_row_in) + 3'd2);
   end

   assign rsp_vec = RSP_W'(rsp);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= LIMIT_RESET;
         scan_row_ff    <= '0;
         write_index_ff <= 1'b0;
         read_index_ff  <= '0;
         port_b_ff      <= '0;
         port_d_ff      <= '0;
         for (int r = 0; r < ROWS; r++) begin
            deb_ff[r] <= '0;
            for (int c = 0; c < COLS; c++) begin
               cnt_ff[r][c] <= '0;
            end
         end
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (req_accept) begin
            scan_row_ff    <= scan_row_in;
            write_index_ff <= write_index_in;
            read_index_ff  <= read_index_in;
            port_b_ff      <= port_b_in;
            port_d_ff      <= port_d_in;
         end
         if (scan_we) begin
            deb_ff[row_next] <= row_bits;
            for (int c = 0; c < COLS; c++) begin
               cnt_ff[row_next][c] <= cnt_row_in[c];
            end
         end
      end
   end

   kpdscan_skid #(
      .WIDTH(RSP_W)
   ) u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (buf_ready),
      .in_data  (rsp_vec),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_tdata)
   );

   `KPD_ASSERT_ALWAYS(a_row_range, clock, reset, scan_row_ff <= RIDX_W'(ROWS - 1))
   `KPD_ASSERT_ALWAYS(a_read_range, clock, reset, read_index_ff <= RD_W'(ROWS))
   `KPD_ASSERT_NEXT(a_wbyte_toggle, clock, reset, req_accept && req_tuser == OP_WBYTE,
                    write_index_ff != $past(write_index_ff))
   `KPD_ASSERT_NEXT(a_raddr_rewind, clock, reset, req_accept && req_tuser == OP_RADDR,
                    read_index_ff == RD_W'(1))

endmodule
